>>> hdl/max_heap_priority_queue_core_defines.svh
// Assertion macros for the max-heap priority queue core.
// Included by the top level; depends on nothing else.
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MHPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhpq check failed");
// antecedent implies consequent in the next cycle
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhpq check failed");
`else
`define MHPQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue core.
// No dependencies.
package mhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [1:0]              status_t;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // result status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

>>> hdl/max_heap_priority_queue_core.sv
// Max-heap priority queue: key store in a dual-read, single-write RAM.
// Depends on mhpq_pkg and max_heap_priority_queue_core_defines.svh.

// A command (op, key) is taken when start is high and busy is low. Its single
// result word appears on status, popped_key and entry_count with done high for
// one cycle; the receiver cannot stall it. The heap walks one level per clock:
// each cycle uses the RAM word read the cycle before and writes back one entry.
// An insert finishes after its sift-up and a pop after its sift-down; a full
// insert or an empty pop answers in the next cycle. busy drops in the done
// cycle, so the next command can be taken there. The store holds at most
// STORE_DEPTH-1 keys; it needs no clearing after reset.
`include "max_heap_priority_queue_core_defines.svh"

module max_heap_priority_queue_core
  import mhpq_pkg::*;
#(
  parameter int STORE_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      op,
  input  logic signed [KEY_W-1:0]   key,
  output logic                      busy,
  output logic                      done,
  output logic [1:0]                status,
  output logic signed [KEY_W-1:0]   popped_key,
  output logic [COUNT_W-1:0]        entry_count
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] CNT_MAX = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] ROOT    = AW'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;

  // key store
  key_t mem [STORE_DEPTH];
  key_t rd_a, rd_b;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  key_t wdata;
  logic we;

  logic [2:0]    state, state_next;
  logic [AW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  key_t          cur, cur_next;
  logic          done_next;
  status_t       status_next;
  key_t          popped_next;
  key_t          top_key, top_key_next;

  logic [AW-1:0] parent;
  logic [AW:0]   lchild, rchild;
  logic          take_l, take_r;
  key_t          best_key;
  logic [AW-1:0] best;
  logic [AW+COUNT_W-1:0] count_ext;
  logic          pop_on_empty;

  // RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // child selection for sift-down (strictly greater wins, left wins a tie)
  assign parent   = pos >> 1;
  assign lchild   = {pos, 1'b0};
  assign rchild   = {pos, 1'b1};
  assign take_l   = (lchild <= {1'b0, count}) && (rd_a > cur);
  assign best_key = take_l ? rd_a : cur;
  assign take_r   = (rchild <= {1'b0, count}) && (rd_b > best_key);
  assign best     = take_r ? rchild[AW-1:0] : lchild[AW-1:0];

  // sequencer
  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    cur_next     = cur;
    top_key_next = top_key;
    done_next    = 1'b0;
    status_next  = ST_DONE;
    popped_next  = '0;
    we           = 1'b0;
    waddr        = pos;
    wdata        = cur;
    raddr_a      = ROOT;
    raddr_b      = ROOT;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_INSERT) begin
            if (count == CNT_MAX) begin
              done_next   = 1'b1;
              status_next = ST_FULL;
            end else begin
              count_next = count + AW'(1);
              pos_next   = count + AW'(1);
              cur_next   = key;
              raddr_a    = (count + AW'(1)) >> 1;
              state_next = (count == '0) ? S_FIN : S_UP;
            end
          end else begin
            if (count == '0) begin
              done_next   = 1'b1;
              status_next = ST_EMPTY;
            end else begin
              raddr_a    = ROOT;
              raddr_b    = count;
              state_next = S_POP;
            end
          end
        end
      end
      S_UP: begin
        // rd_a holds the parent's key
        if (cur > rd_a) begin
          we       = 1'b1;
          waddr    = pos;
          wdata    = rd_a;
          pos_next = parent;
          raddr_a  = parent >> 1;
          if (parent == ROOT) begin
            state_next = S_FIN;
          end
        end else begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        we         = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_POP: begin
        // rd_a is the root, rd_b the last entry
        count_next   = count - AW'(1);
        cur_next     = rd_b;
        top_key_next = rd_a;
        pos_next     = ROOT;
        if (count == ROOT) begin
          done_next   = 1'b1;
          popped_next = rd_a;
          state_next  = S_IDLE;
        end else begin
          raddr_a    = AW'(2);
          raddr_b    = AW'(3);
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wdata    = take_r ? rd_b : rd_a;
          pos_next = best;
          raddr_a  = {best[AW-2:0], 1'b0};
          raddr_b  = {best[AW-2:0], 1'b1};
        end else begin
          done_next   = 1'b1;
          popped_next = top_key;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    cur     <= cur_next;
    top_key <= top_key_next;
    if (done_next) begin
      status      <= status_next;
      popped_key  <= popped_next;
      entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign busy = (state != S_IDLE);

  // pop taken while the heap is empty
  assign pop_on_empty = start && !busy && op == OP_POP && count == '0;

  // checks
  `MHPQ_ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy)
  `MHPQ_ASSERT_NEXT(a_empty_pop, clk, rst, pop_on_empty, done && status == ST_EMPTY)
  `MHPQ_ASSERT_NOW(a_walk_pos_valid, clk, rst, state == S_UP || state == S_DOWN, pos != '0 && pos <= count)

endmodule
